@@ hw/rtl/tanimoto_pair_threshold_count_top_assert.svh @@
// Assertion macros for the Tanimoto pair threshold counter checks
`ifndef TANIMOTO_PAIR_THRESHOLD_COUNT_TOP_ASSERT_SVH
`define TANIMOTO_PAIR_THRESHOLD_COUNT_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define TPC_AST_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define TPC_AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/tpc_pkg.sv @@
// Package: sizes, command codes, token type and popcount for the pair counter
`timescale 1ns / 1ps
`default_nettype none

package tpc_pkg;

  localparam int REF_SLOTS = 64;
  localparam int WORD_W    = 32;
  localparam int POP_W     = 6;
  localparam int CNT_W     = $clog2(REF_SLOTS + 1);
  localparam int CMD_W     = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  typedef struct packed {
    logic              vld;
    logic [WORD_W-1:0] word;
    logic [POP_W-1:0]  pq;
    logic [CNT_W-1:0]  hits;
  } tok_t;

  function automatic logic [POP_W-1:0] popcnt32(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] s1;
    logic [WORD_W-1:0] s2;
    logic [WORD_W-1:0] s4;
    logic [WORD_W-1:0] s8;
    logic [WORD_W-1:0] s16;
    s1  = v - ((v >> 1) & 32'h5555_5555);
    s2  = (s1 & 32'h3333_3333) + ((s1 >> 2) & 32'h3333_3333);
    s4  = (s2 + (s2 >> 4)) & 32'h0F0F_0F0F;
    s8  = s4 + (s4 >> 8);
    s16 = s8 + (s8 >> 16);
    return s16[POP_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tpc_if.sv @@
// Interfaces: command channel and result channel of the pair counter
`timescale 1ns / 1ps
`default_nettype none

interface tpc_in_if import tpc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [WORD_W-1:0] word;
  logic              last;

  modport source(output valid, command, word, last, input ready);
  modport sink(input valid, command, word, last, output ready);
endinterface

interface tpc_out_if import tpc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] match_count;
  logic              refs_dropped;

  modport source(output valid, match_count, refs_dropped, input ready);
  modport sink(input valid, match_count, refs_dropped, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/tpc_cell.sv @@
// Cell: one stored reference, its popcount test and one stage of the query token
`timescale 1ns / 1ps
`default_nettype none

module tpc_cell import tpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load_en,
  input  logic [WORD_W-1:0] ref_word_in,
  input  logic [POP_W-1:0]  ref_pop_in,
  output logic [WORD_W-1:0] ref_word_out,
  output logic [POP_W-1:0]  ref_pop_out,
  input  logic              slot_valid,
  input  tok_t              tok_in,
  output tok_t              tok_out
);

  logic [WORD_W-1:0] ref_word_r;
  logic [POP_W-1:0]  ref_pop_r;
  logic              tok_vld_r;
  logic [WORD_W-1:0] tok_word_r;
  logic [POP_W-1:0]  tok_pq_r;
  logic [CNT_W-1:0]  tok_hits_r;
  logic [CNT_W-1:0]  tok_hits_nxt;
  logic [POP_W-1:0]  common;
  logic [POP_W+1:0]  lhs;
  logic [POP_W+1:0]  rhs;
  logic              hit;

  always_comb begin
    common       = popcnt32(ref_word_r & tok_in.word);
    lhs          = {common, 2'b00};
    rhs          = (POP_W+2)'(ref_pop_r) + (POP_W+2)'(tok_in.pq);
    hit          = slot_valid && (lhs >= rhs);
    tok_hits_nxt = tok_in.hits + CNT_W'(hit);
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      ref_word_r <= ref_word_in;
      ref_pop_r  <= ref_pop_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_r <= 1'b0;
    end else begin
      tok_vld_r <= tok_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    tok_word_r <= tok_in.word;
    tok_pq_r   <= tok_in.pq;
    tok_hits_r <= tok_hits_nxt;
  end

  assign ref_word_out = ref_word_r;
  assign ref_pop_out  = ref_pop_r;
  assign tok_out      = '{vld: tok_vld_r, word: tok_word_r, pq: tok_pq_r, hits: tok_hits_r};

endmodule

`default_nettype wire

@@ hw/rtl/tpc_chain.sv @@
// Chain: row of reference cells; loads shift in at the head, queries walk to the tail
`timescale 1ns / 1ps
`default_nettype none

module tpc_chain import tpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load_en,
  input  logic [WORD_W-1:0] load_word,
  input  logic [POP_W-1:0]  load_pop,
  input  logic [CNT_W-1:0]  loaded_count,
  input  tok_t              tok_in,
  output tok_t              tok_tail
);

  logic [WORD_W-1:0] ref_word_w [REF_SLOTS];
  logic [POP_W-1:0]  ref_pop_w  [REF_SLOTS];
  tok_t              tok_w      [REF_SLOTS+1];

  assign tok_w[0] = tok_in;

  for (genvar i = 0; i < REF_SLOTS; i++) begin : g_cell
    logic [WORD_W-1:0] word_in;
    logic [POP_W-1:0]  pop_in;
    logic              slot_valid;

    if (i == 0) begin : g_head
      assign word_in = load_word;
      assign pop_in  = load_pop;
    end else begin : g_body
      assign word_in = ref_word_w[i-1];
      assign pop_in  = ref_pop_w[i-1];
    end

    assign slot_valid = CNT_W'(i) < loaded_count;

    tpc_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .load_en      (load_en),
      .ref_word_in  (word_in),
      .ref_pop_in   (pop_in),
      .ref_word_out (ref_word_w[i]),
      .ref_pop_out  (ref_pop_w[i]),
      .slot_valid   (slot_valid),
      .tok_in       (tok_w[i]),
      .tok_out      (tok_w[i+1])
    );
  end

  assign tok_tail = tok_w[REF_SLOTS];

endmodule

`default_nettype wire

@@ hw/rtl/tanimoto_pair_threshold_count_top.sv @@
// Top level: Tanimoto pair threshold counter over a chain of reference cells
`timescale 1ns / 1ps
`default_nettype none

// Clear and load transactions never hold the input. A query transaction walks
// the chain of REF_SLOTS reference cells one cell per cycle, and the block
// takes no new transaction until the hits of that query are added to the
// total; a query with last set waits longer only while an earlier result is
// still held on the output. Up to REF_SLOTS references are kept; loads past
// that are dropped and reported through refs_dropped until the next clear.
// The total saturates at 2^32-1 and is emitted and cleared on a last query.
module tanimoto_pair_threshold_count_top import tpc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  tpc_in_if.sink    in_ch,
  tpc_out_if.source out_ch
);

  logic              busy_r,      busy_nxt;
  logic              last_r,      last_nxt;
  logic              pend_vld_r,  pend_vld_nxt;
  logic [CNT_W-1:0]  pend_hits_r, pend_hits_nxt;
  logic [CNT_W-1:0]  loaded_r,    loaded_nxt;
  logic [WORD_W-1:0] total_r,     total_nxt;
  logic              ovf_r,       ovf_nxt;
  logic              out_vld_r,   out_vld_nxt;
  logic [WORD_W-1:0] out_cnt_r,   out_cnt_nxt;
  logic              out_drop_r,  out_drop_nxt;

  logic              acc;
  cmd_t              cmd;
  logic              load_en;
  tok_t              tok_in;
  tok_t              tok_tail;
  logic              fin;
  logic [WORD_W:0]   sum;
  logic [WORD_W-1:0] sat;

  assign in_ch.ready = !busy_r;
  assign acc         = in_ch.valid && !busy_r;
  assign cmd         = cmd_t'(in_ch.command);
  assign load_en     = acc && (cmd == CMD_LOAD) && (loaded_r != CNT_W'(REF_SLOTS));

  assign tok_in = '{vld: acc && (cmd == CMD_QUERY), word: in_ch.word,
                    pq: popcnt32(in_ch.word), hits: '0};

  tpc_chain u_chain (
    .clk          (clk),
    .rst_n        (rst_n),
    .load_en      (load_en),
    .load_word    (in_ch.word),
    .load_pop     (popcnt32(in_ch.word)),
    .loaded_count (loaded_r),
    .tok_in       (tok_in),
    .tok_tail     (tok_tail)
  );

  assign fin = pend_vld_r && (!last_r || !out_vld_r || out_ch.ready);
  assign sum = {1'b0, total_r} + (WORD_W+1)'(pend_hits_r);
  assign sat = sum[WORD_W] ? '1 : sum[WORD_W-1:0];

  always_comb begin
    busy_nxt      = busy_r;
    last_nxt      = last_r;
    pend_vld_nxt  = pend_vld_r;
    pend_hits_nxt = pend_hits_r;
    loaded_nxt    = loaded_r;
    total_nxt     = total_r;
    ovf_nxt       = ovf_r;
    out_vld_nxt   = out_vld_r;
    out_cnt_nxt   = out_cnt_r;
    out_drop_nxt  = out_drop_r;

    if (out_vld_r && out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end

    if (acc) begin
      case (cmd)
        CMD_CLEAR: begin
          loaded_nxt = '0;
          total_nxt  = '0;
          ovf_nxt    = 1'b0;
        end
        CMD_LOAD: begin
          if (load_en) begin
            loaded_nxt = loaded_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        CMD_QUERY: begin
          busy_nxt = 1'b1;
          last_nxt = in_ch.last;
        end
        default: begin
        end
      endcase
    end

    if (tok_tail.vld) begin
      pend_vld_nxt  = 1'b1;
      pend_hits_nxt = tok_tail.hits;
    end

    if (fin) begin
      pend_vld_nxt = 1'b0;
      busy_nxt     = 1'b0;
      if (last_r) begin
        out_vld_nxt  = 1'b1;
        out_cnt_nxt  = sat;
        out_drop_nxt = ovf_r;
        total_nxt    = '0;
      end else begin
        total_nxt = sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      pend_vld_r <= 1'b0;
      loaded_r   <= '0;
      total_r    <= '0;
      ovf_r      <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      pend_vld_r <= pend_vld_nxt;
      loaded_r   <= loaded_nxt;
      total_r    <= total_nxt;
      ovf_r      <= ovf_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r      <= last_nxt;
    pend_hits_r <= pend_hits_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_drop_r  <= out_drop_nxt;
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.match_count  = out_cnt_r;
  assign out_ch.refs_dropped = out_drop_r;

endmodule

`default_nettype wire

@@ hw/rtl/tpc_checker.sv @@
// Checker: port-level assertions for the pair counter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "tanimoto_pair_threshold_count_top_assert.svh"

module tpc_checker import tpc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [CMD_W-1:0]  in_command,
  input logic              out_valid,
  input logic              out_ready,
  input logic [WORD_W-1:0] out_match_count,
  input logic              out_refs_dropped
);

  logic            in_fire;
  logic            query_fire;
  logic            short_fire;
  logic            out_stall;
  logic [WORD_W:0] out_data;

  assign in_fire    = in_valid && in_ready;
  assign query_fire = in_fire && (in_command == CMD_QUERY);
  assign short_fire = in_fire && ((in_command == CMD_CLEAR) || (in_command == CMD_LOAD));
  assign out_stall  = out_valid && !out_ready;
  assign out_data   = {out_match_count, out_refs_dropped};

  `TPC_AST_NEXT(a_out_hold, out_stall, out_valid && $stable(out_data), "result changed in stall")
  `TPC_AST_NEXT(a_query_busy, query_fire, !in_ready, "query did not block the input")
  `TPC_AST_NEXT(a_short_cmd, short_fire, in_ready, "clear or load held the input")
  `TPC_AST_SAME(a_emit_after_busy, $rose(out_valid), $past(!in_ready), "no query in flight")

endmodule

bind tanimoto_pair_threshold_count_top tpc_checker u_tpc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_command       (in_ch.command),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_match_count  (out_ch.match_count),
  .out_refs_dropped (out_ch.refs_dropped)
);

`default_nettype wire
